// ===== rtl/core/setq_pkg.sv =====
package setq_pkg;

  // Ring geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FIRST  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_SECOND = CFG_INDEX_W'(1);

  // Operation codes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_STOP    = 3'd1;
  localparam logic [2:0] OP_RECORD  = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_LATEST  = 3'd4;
  localparam logic [2:0] OP_CONVERT = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic        source;
    logic [63:0] tick_us;
  } setq_in_t;

  typedef struct packed {
    logic        out_valid;
    logic        out_source;
    logic [31:0] out_sequence;
    logic [63:0] out_tick_us;
    logic [31:0] out_period_us;
    logic        out_overflow;
    logic [31:0] out_dropped;
    logic [31:0] session_number;
    logic        is_active;
  } setq_out_t;

  // One ring slot; entries are only written when the ring has room,
  // so the overflow flag of a stored entry is always clear
  typedef struct packed {
    logic [63:0] tick;
    logic [31:0] sequence_num;
    logic [31:0] period;
    logic [31:0] dropped;
    logic        source;
  } ring_entry_t;

  localparam int ENTRY_W = $bits(ring_entry_t);

  // Advance a ring pointer modulo the depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/setq_ram.sv =====
module setq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sync_event_timestamp_queue.sv =====
// Sync event timestamp queue.
// Command words enter on cmd_valid/cmd_ready (operation, source, tick_us);
// every accepted word yields exactly one result word on res_valid/res_ready.
// Operations: start session, stop, record event, pop, read latest record
// and convert a tick to session-relative time. The ring of stored events
// sits in one synchronous RAM; the latest records, sequences and pointers
// are in flip-flops. Nominal periods are written on the cfg channel
// (index 0: source zero, index 1: source one), always ready.
// Each result is registered in the output register or skid stage; a pop of a
// non-empty ring first goes through the registered RAM read and the ST_POP
// state. Other operations answer directly, so the block sustains one word a
// cycle between pops while the skid stage is empty. The output register is
// backed by a one-word skid stage, so a new command is taken while a finished
// result waits; cmd_ready drops only once both hold a word or a pop read is in flight.
// Reset clears the session, pointers, counters, latest records and output
// valids; the ring contents are left undefined and never read before written.
module sync_event_timestamp_queue
  import setq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  setq_in_t               cmd_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output setq_out_t              res_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

  state_t state, state_next;

  // Session state
  logic [31:0]      period_first, period_second;
  logic             session_active, session_active_next;
  logic [31:0]      session_counter, session_counter_next;
  logic [63:0]      session_start, session_start_next;
  logic [31:0]      drop_total, drop_total_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [31:0]      source_seq [2];
  logic [31:0]      source_seq_next [2];

  // Latest record per source
  logic [63:0] latest_tick [2];
  logic [31:0] latest_seq [2];
  logic [31:0] latest_period [2];
  logic [31:0] latest_dropped [2];
  logic [1:0]  latest_flag [2];
  logic [63:0] latest_tick_next [2];
  logic [31:0] latest_seq_next [2];
  logic [31:0] latest_period_next [2];
  logic [31:0] latest_dropped_next [2];
  logic [1:0]  latest_flag_next [2];

  // Ring memory
  logic        ram_we, ram_re;
  ring_entry_t ram_wdata, ram_rdata;

  // Output register and skid stage
  logic      hold_valid;
  setq_out_t hold_data;
  logic      result_fire;
  setq_out_t result;

  logic        cmd_fire;
  logic        src;
  logic [64:0] rel_diff;
  logic [63:0] rel_tick;
  logic [31:0] cur_seq;
  logic [31:0] cur_period;
  logic        ring_full;

  assign cmd_ready = (state == ST_IDLE) && !hold_valid;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign cfg_ready = 1'b1;

  // Session-relative tick, clamped at zero
  assign rel_diff = {1'b0, cmd_data.tick_us} - {1'b0, session_start};
  assign rel_tick = rel_diff[64] ? 64'd0 : rel_diff[63:0];

  assign src        = cmd_data.source;
  assign cur_seq    = source_seq[src];
  assign cur_period = src ? period_second : period_first;
  assign ring_full  = (ptr_inc(wr_ptr) == rd_ptr);

  setq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_ptr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (rd_ptr),
    .rd_data (ram_rdata)
  );

  // Decode the command and work out the next state and the result word
  always_comb begin
    state_next           = state;
    session_active_next  = session_active;
    session_counter_next = session_counter;
    session_start_next   = session_start;
    drop_total_next      = drop_total;
    wr_ptr_next          = wr_ptr;
    rd_ptr_next          = rd_ptr;
    for (int i = 0; i < 2; i++) begin
      source_seq_next[i]     = source_seq[i];
      latest_tick_next[i]    = latest_tick[i];
      latest_seq_next[i]     = latest_seq[i];
      latest_period_next[i]  = latest_period[i];
      latest_dropped_next[i] = latest_dropped[i];
      latest_flag_next[i]    = latest_flag[i];
    end
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = '{tick: rel_tick, sequence_num: cur_seq, period: cur_period,
                    dropped: drop_total, source: src};
    result      = '0;
    result_fire = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          result_fire = 1'b1;
          unique case (cmd_data.operation)
            OP_START: begin
              wr_ptr_next          = '0;
              rd_ptr_next          = '0;
              drop_total_next      = '0;
              session_start_next   = cmd_data.tick_us;
              session_counter_next = session_counter + 32'd1;
              session_active_next  = 1'b1;
              for (int i = 0; i < 2; i++) begin
                source_seq_next[i]     = '0;
                latest_tick_next[i]    = '0;
                latest_seq_next[i]     = '0;
                latest_period_next[i]  = '0;
                latest_dropped_next[i] = '0;
                latest_flag_next[i]    = '0;
              end
            end
            OP_STOP: begin
              session_active_next = 1'b0;
              wr_ptr_next         = '0;
              rd_ptr_next         = '0;
              drop_total_next     = '0;
              for (int i = 0; i < 2; i++) begin
                latest_tick_next[i]    = '0;
                latest_seq_next[i]     = '0;
                latest_period_next[i]  = '0;
                latest_dropped_next[i] = '0;
                latest_flag_next[i]    = '0;
              end
            end
            OP_RECORD: begin
              if (session_active) begin
                source_seq_next[src] = cur_seq + 32'd1;
                if (ring_full) begin
                  drop_total_next = drop_total + 32'd1;
                end else begin
                  ram_we      = 1'b1;
                  wr_ptr_next = ptr_inc(wr_ptr);
                end
                latest_tick_next[src]    = rel_tick;
                latest_seq_next[src]     = cur_seq;
                latest_period_next[src]  = cur_period;
                latest_dropped_next[src] = drop_total_next;
                latest_flag_next[src]    = {ring_full, src};
                result.out_valid     = 1'b1;
                result.out_source    = src;
                result.out_sequence  = cur_seq;
                result.out_tick_us   = rel_tick;
                result.out_period_us = cur_period;
                result.out_overflow  = ring_full;
                result.out_dropped   = drop_total_next;
              end
            end
            OP_POP: begin
              // Non-empty ring: read the head and answer next cycle
              if (rd_ptr != wr_ptr) begin
                ram_re      = 1'b1;
                rd_ptr_next = ptr_inc(rd_ptr);
                state_next  = ST_POP;
                result_fire = 1'b0;
              end
            end
            OP_LATEST: begin
              result.out_valid     = session_active && (cur_seq != 32'd0);
              result.out_source    = latest_flag[src][0];
              result.out_sequence  = latest_seq[src];
              result.out_tick_us   = latest_tick[src];
              result.out_period_us = latest_period[src];
              result.out_overflow  = latest_flag[src][1];
              result.out_dropped   = latest_dropped[src];
            end
            OP_CONVERT: begin
              result.out_tick_us = session_active ? rel_tick : 64'd0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        result_fire          = 1'b1;
        result.out_valid     = 1'b1;
        result.out_source    = ram_rdata.source;
        result.out_sequence  = ram_rdata.sequence_num;
        result.out_tick_us   = ram_rdata.tick;
        result.out_period_us = ram_rdata.period;
        result.out_dropped   = ram_rdata.dropped;
        state_next           = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    result.session_number = session_counter_next;
    result.is_active      = session_active_next;
  end

  // Advance control and session state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      session_active  <= 1'b0;
      session_counter <= '0;
      session_start   <= '0;
      drop_total      <= '0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      for (int i = 0; i < 2; i++) begin
        source_seq[i]     <= '0;
        latest_tick[i]    <= '0;
        latest_seq[i]     <= '0;
        latest_period[i]  <= '0;
        latest_dropped[i] <= '0;
        latest_flag[i]    <= '0;
      end
    end else begin
      state           <= state_next;
      session_active  <= session_active_next;
      session_counter <= session_counter_next;
      session_start   <= session_start_next;
      drop_total      <= drop_total_next;
      wr_ptr          <= wr_ptr_next;
      rd_ptr          <= rd_ptr_next;
      for (int i = 0; i < 2; i++) begin
        source_seq[i]     <= source_seq_next[i];
        latest_tick[i]    <= latest_tick_next[i];
        latest_seq[i]     <= latest_seq_next[i];
        latest_period[i]  <= latest_period_next[i];
        latest_dropped[i] <= latest_dropped_next[i];
        latest_flag[i]    <= latest_flag_next[i];
      end
    end
  end

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      period_first  <= '0;
      period_second <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PERIOD_FIRST:  period_first  <= cfg_data;
        CFG_PERIOD_SECOND: period_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Output register with skid stage behind it; the skid stage is always
  // empty when a new result is produced
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (result_fire) begin
      if (!res_valid || res_ready) begin
        res_data  <= result;
        res_valid <= 1'b1;
      end else begin
        hold_data  <= result;
        hold_valid <= 1'b1;
      end
    end else if (res_valid && res_ready) begin
      if (hold_valid) begin
        res_data   <= hold_data;
        hold_valid <= 1'b0;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  // A word in the skid stage always has one ahead of it
  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> res_valid)
    else $error("skid word without output word");

  // A new result never meets a full skid stage
  a_result_room: assert property (@(posedge clk) disable iff (rst)
    result_fire |-> !hold_valid)
    else $error("result produced with skid stage full");

  // A pop read always returns to ST_IDLE in the next cycle
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (state == ST_IDLE))
    else $error("pop read did not finish");

  // No command is taken while a pop read is in flight
  a_no_cmd_in_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |-> !cmd_ready)
    else $error("command taken during pop read");

  // A non-empty pop fills the output path on the following cycle
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (res_valid && $past(hold_valid == 1'b0)))
    else $error("pop result lost");

  // A start leaves the session active with a bumped number
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && cmd_data.operation == OP_START)
      |=> (session_active && session_counter == $past(session_counter) + 32'd1))
    else $error("start did not open a session");

endmodule
